// ===== sv/mfs_pkg.sv =====
// Shared types and constants of the multilevel feedback queue scheduler.
package mfs_pkg;

  localparam int MAX_PROCS  = 64;
  localparam int MAX_LEVELS = 5;
  localparam int SLOT_W     = $clog2(MAX_PROCS);
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int CNT_W      = $clog2(MAX_PROCS + 1);
  localparam int FIFO_AW    = LVL_W + SLOT_W;
  localparam int FIFO_DEPTH = MAX_LEVELS * MAX_PROCS;
  localparam int RAN_W      = 14;

  localparam logic [1:0] EV_RUNS     = 2'd0;
  localparam logic [1:0] EV_FINISHED = 2'd1;
  localparam logic [1:0] EV_SWITCHED = 2'd2;
  localparam logic [1:0] EV_REJECTED = 2'd3;

  localparam logic [1:0] CFG_LEVEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_TOP_QUANTUM = 2'd1;
  localparam logic [1:0] CFG_AGE_LIMIT   = 2'd2;

  localparam logic [1:0] RD_BOTTOM = 2'd0;
  localparam logic [1:0] RD_CUR    = 2'd1;
  localparam logic [1:0] RD_TOP    = 2'd2;

  typedef struct packed {
    logic [15:0]      pid;
    logic [15:0]      remaining;
    logic [15:0]      burst;
    logic [31:0]      arrival;
    logic [15:0]      age;
    logic [RAN_W-1:0] ran;
  } slot_t;

  typedef struct packed {
    logic       latch;
    logic       arr_commit;
    logic       arr_reject;
    logic [1:0] rd_src;
    logic       age_step;
    logic       svc_skip;
    logic       svc_exec;
    logic       emit_pending;
    logic       emit_last;
    logic       start_run;
    logic       emit_runs;
    logic       advance_clock;
  } cmd_t;

  typedef struct packed {
    logic             reject;
    logic             age_needed;
    logic [CNT_W-1:0] bottom_count;
    logic             svc_ok;
    logic             need_run;
  } stat_t;

endpackage

// ===== sv/mfs_ctrl.sv =====
// Sequencer of the scheduler: arrival, aging walk, service and dispatch steps.
module mfs_ctrl import mfs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  mode,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ARR       = 4'd1;
  localparam logic [3:0] S_TICK_INIT = 4'd2;
  localparam logic [3:0] S_AGE_LOOP  = 4'd3;
  localparam logic [3:0] S_AGE_SLOT  = 4'd4;
  localparam logic [3:0] S_AGE_WR    = 4'd5;
  localparam logic [3:0] S_SVC_CHECK = 4'd6;
  localparam logic [3:0] S_SVC_SLOT  = 4'd7;
  localparam logic [3:0] S_SVC_EXEC  = 4'd8;
  localparam logic [3:0] S_RUN_CHECK = 4'd9;
  localparam logic [3:0] S_RUN_SLOT  = 4'd10;
  localparam logic [3:0] S_RUN_EMIT  = 4'd11;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] age_cnt, age_cnt_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.rd_src   = RD_CUR;
    state_next   = state;
    age_cnt_next = age_cnt;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = mode ? S_TICK_INIT : S_ARR;
        end
      end
      S_ARR: begin
        if (stat.reject) cmd.arr_reject = 1'b1;
        else cmd.arr_commit = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK_INIT: begin
        if (stat.age_needed) begin
          age_cnt_next = stat.bottom_count;
          state_next   = S_AGE_LOOP;
        end else begin
          state_next = S_SVC_CHECK;
        end
      end
      S_AGE_LOOP: begin
        cmd.rd_src = RD_BOTTOM;
        state_next = (age_cnt == '0) ? S_SVC_CHECK : S_AGE_SLOT;
      end
      S_AGE_SLOT: state_next = S_AGE_WR;
      S_AGE_WR: begin
        cmd.age_step = 1'b1;
        age_cnt_next = age_cnt - 1'b1;
        state_next   = S_AGE_LOOP;
      end
      S_SVC_CHECK: begin
        cmd.rd_src = RD_CUR;
        if (stat.svc_ok) begin
          state_next = S_SVC_SLOT;
        end else begin
          cmd.svc_skip = 1'b1;
          state_next   = S_RUN_CHECK;
        end
      end
      S_SVC_SLOT: state_next = S_SVC_EXEC;
      S_SVC_EXEC: begin
        cmd.svc_exec = 1'b1;
        state_next   = S_RUN_CHECK;
      end
      S_RUN_CHECK: begin
        cmd.rd_src       = RD_TOP;
        cmd.emit_pending = 1'b1;
        if (stat.need_run) begin
          cmd.start_run = 1'b1;
          state_next    = S_RUN_SLOT;
        end else begin
          cmd.emit_last     = 1'b1;
          cmd.advance_clock = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_RUN_SLOT: state_next = S_RUN_EMIT;
      S_RUN_EMIT: begin
        cmd.emit_runs     = 1'b1;
        cmd.advance_clock = 1'b1;
        state_next        = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      age_cnt <= '0;
    end else begin
      state   <= state_next;
      age_cnt <= age_cnt_next;
    end
  end

endmodule

// ===== sv/mfs_datapath.sv =====
// Datapath of the scheduler: slot table, level queues, clock, config and result registers.
module mfs_datapath import mfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [15:0] proc_id,
  input  logic [15:0] burst_len,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        event_valid,
  output logic [1:0]  event_res,
  output logic [15:0] event_pid,
  output logic [31:0] event_time,
  output logic [31:0] turnaround,
  output logic [31:0] queue_wait,
  output logic        last
);

  logic [2:0]  level_count;
  logic [10:0] top_quantum;
  logic [15:0] age_limit;

  slot_t               slot_mem [MAX_PROCS];
  logic [SLOT_W-1:0]   fifo_mem [FIFO_DEPTH];
  logic [SLOT_W-1:0]   fifo_head [MAX_LEVELS];
  logic [CNT_W-1:0]    fifo_count [MAX_LEVELS];
  logic [MAX_PROCS-1:0] free_map;
  logic [31:0]         tick_clock;
  logic                running;
  logic [LVL_W-1:0]    cur_level;

  logic [15:0]       in_pid, in_burst;
  logic [SLOT_W-1:0] fifo_rdata, cur_slot;
  slot_t             slot_rdata;

  logic              pend_valid;
  logic [1:0]        pend_res;
  logic [15:0]       pend_pid;
  logic [31:0]       pend_ta, pend_wt;

  logic [LVL_W-1:0]   bottom, top_lvl, rd_lvl;
  logic               top_valid;
  logic [SLOT_W-1:0]  found_slot;
  logic               table_full;
  logic [FIFO_AW-1:0] fifo_raddr;

  logic [15:0]      rem_new;
  logic [RAN_W-1:0] ran_new, quantum;
  logic             upper, finish, switch_dn;
  logic [16:0]      age_inc, age_lim;
  logic             promote;
  logic [31:0]      ta_calc;

  logic               pop_en, push_en, slot_we;
  logic [LVL_W-1:0]   pop_lvl, push_lvl;
  logic [SLOT_W-1:0]  push_slot, slot_waddr, push_pos;
  slot_t              slot_wdata;

  always_comb begin
    bottom = LVL_W'(MAX_LEVELS - 1);
    if (level_count < 3'd2) bottom = LVL_W'(1);
    else if (32'(level_count) < MAX_LEVELS) bottom = LVL_W'(level_count - 3'd1);
  end

  always_comb begin
    top_valid = 1'b0;
    top_lvl   = '0;
    for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
      if (fifo_count[l] != '0) begin
        top_valid = 1'b1;
        top_lvl   = LVL_W'(l);
      end
    end
  end

  always_comb begin
    found_slot = '0;
    for (int s = MAX_PROCS - 1; s >= 0; s--) begin
      if (free_map[s]) found_slot = SLOT_W'(s);
    end
  end
  assign table_full = (free_map == '0);

  always_comb begin
    case (cmd.rd_src)
      RD_BOTTOM: rd_lvl = bottom;
      RD_TOP:    rd_lvl = top_lvl;
      default:   rd_lvl = cur_level;
    endcase
  end
  assign fifo_raddr = {rd_lvl, fifo_head[rd_lvl]};

  assign upper     = (cur_level < bottom);
  assign rem_new   = (slot_rdata.remaining != '0) ? slot_rdata.remaining - 16'd1 : 16'd0;
  assign ran_new   = upper ? slot_rdata.ran + 1'b1 : slot_rdata.ran;
  assign quantum   = RAN_W'({3'b000, top_quantum} << cur_level);
  assign finish    = (rem_new == '0);
  assign switch_dn = upper && (ran_new >= quantum);
  assign ta_calc   = tick_clock - slot_rdata.arrival;
  assign age_inc   = {1'b0, slot_rdata.age} + 17'd1;
  assign age_lim   = (age_limit == '0) ? 17'd1 : {1'b0, age_limit};
  assign promote   = (age_inc >= age_lim);

  always_comb begin
    pop_en     = 1'b0;
    pop_lvl    = cur_level;
    push_en    = 1'b0;
    push_lvl   = '0;
    push_slot  = cur_slot;
    slot_we    = 1'b0;
    slot_waddr = cur_slot;
    slot_wdata = slot_rdata;
    if (cmd.arr_commit) begin
      push_en    = 1'b1;
      push_slot  = found_slot;
      slot_we    = 1'b1;
      slot_waddr = found_slot;
      slot_wdata = '{pid: in_pid, remaining: in_burst, burst: in_burst,
                     arrival: tick_clock, age: 16'd0, ran: '0};
    end
    if (cmd.age_step) begin
      pop_en   = 1'b1;
      pop_lvl  = bottom;
      push_en  = 1'b1;
      push_lvl = promote ? bottom - 1'b1 : bottom;
      slot_we  = 1'b1;
      slot_wdata.age = promote ? 16'd0 : age_inc[15:0];
    end
    if (cmd.svc_exec) begin
      slot_we              = 1'b1;
      slot_wdata.remaining = rem_new;
      slot_wdata.ran       = ran_new;
      if (finish) begin
        pop_en = 1'b1;
      end else if (switch_dn) begin
        pop_en         = 1'b1;
        push_en        = 1'b1;
        push_lvl       = cur_level + 1'b1;
        slot_wdata.ran = '0;
        slot_wdata.age = 16'd0;
      end
    end
  end

  assign push_pos = fifo_head[push_lvl] + fifo_count[push_lvl][SLOT_W-1:0];

  always_ff @(posedge clk) begin
    fifo_rdata <= fifo_mem[fifo_raddr];
    cur_slot   <= fifo_rdata;
    slot_rdata <= slot_mem[fifo_rdata];
    if (push_en) fifo_mem[{push_lvl, push_pos}] <= push_slot;
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < MAX_LEVELS; l++) begin
        fifo_head[l]  <= '0;
        fifo_count[l] <= '0;
      end
    end else begin
      for (int l = 0; l < MAX_LEVELS; l++) begin
        if (pop_en && (pop_lvl == LVL_W'(l))) fifo_head[l] <= fifo_head[l] + 1'b1;
        if ((push_en && (push_lvl == LVL_W'(l))) && !(pop_en && (pop_lvl == LVL_W'(l))))
          fifo_count[l] <= fifo_count[l] + 1'b1;
        else if (!(push_en && (push_lvl == LVL_W'(l))) && (pop_en && (pop_lvl == LVL_W'(l))))
          fifo_count[l] <= fifo_count[l] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= 3'd3;
      top_quantum <= 11'd1;
      age_limit   <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL_COUNT: level_count <= cfg_data[2:0];
        CFG_TOP_QUANTUM: top_quantum <= cfg_data[10:0];
        CFG_AGE_LIMIT:   age_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_pid   <= proc_id;
      in_burst <= burst_len;
    end
    if (cmd.svc_exec) begin
      pend_pid <= slot_rdata.pid;
      pend_res <= finish ? EV_FINISHED : EV_SWITCHED;
      pend_ta  <= finish ? ta_calc : 32'd0;
      pend_wt  <= finish ? ta_calc - {16'd0, slot_rdata.burst} : 32'd0;
    end
    event_res  <= EV_RUNS;
    event_pid  <= slot_rdata.pid;
    event_time <= tick_clock;
    turnaround <= 32'd0;
    queue_wait <= 32'd0;
    last       <= 1'b1;
    if (cmd.arr_reject) begin
      event_res <= EV_REJECTED;
      event_pid <= in_pid;
    end else if (cmd.emit_pending) begin
      event_res  <= pend_res;
      event_pid  <= pend_pid;
      turnaround <= pend_ta;
      queue_wait <= pend_wt;
      last       <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map    <= '1;
      tick_clock  <= '0;
      running     <= 1'b0;
      cur_level   <= '0;
      pend_valid  <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      event_valid <= cmd.arr_reject || cmd.emit_runs || (cmd.emit_pending && pend_valid);
      if (cmd.latch) pend_valid <= 1'b0;
      if (cmd.arr_commit) free_map[found_slot] <= 1'b0;
      if (cmd.svc_skip) running <= 1'b0;
      if (cmd.svc_exec) begin
        if (finish) begin
          pend_valid         <= 1'b1;
          free_map[cur_slot] <= 1'b1;
          running            <= 1'b0;
        end else if (switch_dn) begin
          pend_valid <= 1'b1;
          running    <= 1'b0;
        end else if (top_valid && (top_lvl < cur_level)) begin
          running <= 1'b0;
        end
      end
      if (cmd.start_run) begin
        cur_level <= top_lvl;
        running   <= 1'b1;
      end
      if (cmd.advance_clock) tick_clock <= tick_clock + 32'd1;
    end
  end

  assign stat.reject       = (in_burst == '0) || table_full;
  assign stat.age_needed   = (cur_level < bottom);
  assign stat.bottom_count = fifo_count[bottom];
  assign stat.svc_ok       = running && (fifo_count[cur_level] != '0);
  assign stat.need_run     = !running && top_valid;

endmodule

// ===== sv/multilevel_feedback_scheduler.sv =====
// Top level of the multilevel feedback queue scheduler.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  command  | start, busy            | mode, proc_id, burst_len
//  result   | event_valid (1 cycle)  | event_res, event_pid, event_time,
//           |                        | turnaround, queue_wait, last
//  config   | cfg_we                 | cfg_index, cfg_data
//
// An arrival latches the command, then commits or rejects it. A tick runs service and
// dispatch steps; while the running level is above the bottom, it first walks each process
// waiting in the bottom level (one queue read, one slot read, one write-back per entry)
// and then leaves the aging walk.
// The registered reads of the slot table and queue memory set these steps.
// Reset is synchronous; the queues start empty and all slots free, no clearing pass.
// Results are strobed for one cycle each; the receiver cannot stall.
module multilevel_feedback_scheduler import mfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [15:0] proc_id,
  input  logic [15:0] burst_len,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        event_valid,
  output logic [1:0]  event_res,
  output logic [15:0] event_pid,
  output logic [31:0] event_time,
  output logic [31:0] turnaround,
  output logic [31:0] queue_wait,
  output logic        last
);

  cmd_t  cmd;
  stat_t stat;

  mfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mfs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .proc_id     (proc_id),
    .burst_len   (burst_len),
    .cmd         (cmd),
    .stat        (stat),
    .event_valid (event_valid),
    .event_res   (event_res),
    .event_pid   (event_pid),
    .event_time  (event_time),
    .turnaround  (turnaround),
    .queue_wait  (queue_wait),
    .last        (last)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the multilevel feedback queue scheduler: directed table, random phases, predictor.
`timescale 1ns / 100ps
module tb;
  import mfs_pkg::*;

  typedef struct {
    logic [1:0]  res;
    logic [15:0] pid;
    logic [31:0] tstamp;
    logic [31:0] ta;
    logic [31:0] wt;
    logic        fin;
  } event_t;

  typedef struct {
    logic        md;
    logic [15:0] pid;
    logic [15:0] burst;
    bit          typed;
    event_t      ev;
  } row_t;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE   = 300;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic mode = 0;
  logic [15:0] proc_id = 0;
  logic [15:0] burst_len = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CFG_LEVEL_COUNT;
  logic [15:0] cfg_data = 0;
  logic event_valid;
  logic [1:0] event_res;
  logic [15:0] event_pid;
  logic [31:0] event_time, turnaround, queue_wait;
  logic last;

  event_t pending_events[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit no_idle = 0;

  int unsigned sl_pid[MAX_PROCS], sl_rem[MAX_PROCS], sl_burst[MAX_PROCS];
  int unsigned sl_arr[MAX_PROCS], sl_age[MAX_PROCS], sl_ran[MAX_PROCS];
  int unsigned lvl_q[MAX_LEVELS][MAX_PROCS];
  int unsigned lvl_head[MAX_LEVELS], lvl_cnt[MAX_LEVELS];
  bit slot_free[MAX_PROCS];
  int unsigned sched_clock, cur_lvl, n_levels, quantum0, promote_at;
  bit running;

  multilevel_feedback_scheduler DUT (.*);

  always #5 clk = ~clk;

  function automatic int unsigned bottom_lvl();
    int unsigned n;
    n = n_levels;
    if (n < 2) n = 2;
    if (n > MAX_LEVELS) n = MAX_LEVELS;
    return n - 1;
  endfunction

  function automatic void lvl_push(int unsigned l, int unsigned s);
    int unsigned idx;
    if (l >= MAX_LEVELS || lvl_cnt[l] >= MAX_PROCS) return;
    idx = (lvl_head[l] + lvl_cnt[l]) % MAX_PROCS;
    lvl_q[l][idx] = s;
    lvl_cnt[l]++;
  endfunction

  function automatic int unsigned lvl_pop(int unsigned l);
    int unsigned s;
    s = lvl_q[l][lvl_head[l]];
    lvl_head[l] = (lvl_head[l] + 1) % MAX_PROCS;
    lvl_cnt[l]--;
    return s;
  endfunction

  function automatic int top_busy_lvl();
    for (int l = 0; l < MAX_LEVELS; l++)
      if (lvl_cnt[l] != 0) return l;
    return -1;
  endfunction

  function automatic void scheduler_reset();
    for (int l = 0; l < MAX_LEVELS; l++) begin
      lvl_head[l] = 0;
      lvl_cnt[l] = 0;
    end
    foreach (slot_free[s]) slot_free[s] = 1;
    sched_clock = 0;
    running = 0;
    cur_lvl = 0;
    n_levels = 3;
    quantum0 = 1;
    promote_at = 1;
  endfunction

  function automatic event_t mk_event(logic [1:0] r, int unsigned p, int unsigned t,
                                      int unsigned a, int unsigned w);
    event_t e;
    e.res = r;
    e.pid = p[15:0];
    e.tstamp = t;
    e.ta = a;
    e.wt = w;
    e.fin = 0;
    return e;
  endfunction

  function automatic void schedule_step(logic md, logic [15:0] pid, logic [15:0] burst,
                                        ref event_t evs[$]);
    int found, top;
    int unsigned b, n, s, a, lim, t, ta, cl;
    bit upper;
    evs.delete();
    t = sched_clock;
    if (!md) begin
      found = -1;
      for (int i = 0; i < MAX_PROCS; i++)
        if (slot_free[i] && found < 0) found = i;
      if (burst == 0 || found < 0) begin
        evs.insert(evs.size(), mk_event(EV_REJECTED, pid, t, 0, 0));
        evs[0].fin = 1;
        return;
      end
      slot_free[found] = 0;
      sl_pid[found] = pid;
      sl_rem[found] = burst;
      sl_burst[found] = burst;
      sl_arr[found] = t;
      sl_age[found] = 0;
      sl_ran[found] = 0;
      lvl_push(0, found);
      return;
    end
    b = bottom_lvl();
    if (cur_lvl < b) begin
      lim = (promote_at != 0) ? promote_at : 1;
      n = lvl_cnt[b];
      for (int i = 0; i < n; i++) begin
        s = lvl_pop(b);
        a = sl_age[s] + 1;
        if (a >= lim) begin
          sl_age[s] = 0;
          lvl_push(b - 1, s);
        end else begin
          sl_age[s] = a;
          lvl_push(b, s);
        end
      end
    end
    if (running && cur_lvl < MAX_LEVELS && lvl_cnt[cur_lvl] != 0) begin
      cl = cur_lvl;
      s = lvl_q[cl][lvl_head[cl]];
      upper = cl < b;
      if (sl_rem[s] != 0) sl_rem[s]--;
      if (upper) sl_ran[s]++;
      if (sl_rem[s] == 0) begin
        ta = t - sl_arr[s];
        evs.insert(evs.size(), mk_event(EV_FINISHED, sl_pid[s], t, ta, ta - sl_burst[s]));
        void'(lvl_pop(cl));
        slot_free[s] = 1;
        running = 0;
      end else if (upper && sl_ran[s] >= (quantum0 << cl)) begin
        evs.insert(evs.size(), mk_event(EV_SWITCHED, sl_pid[s], t, 0, 0));
        void'(lvl_pop(cl));
        sl_ran[s] = 0;
        sl_age[s] = 0;
        lvl_push(cl + 1, s);
        running = 0;
      end else begin
        top = top_busy_lvl();
        if (top >= 0 && top < cl) running = 0;
      end
    end else begin
      running = 0;
    end
    if (!running) begin
      top = top_busy_lvl();
      if (top >= 0) begin
        cur_lvl = top;
        running = 1;
        evs.insert(evs.size(),
                   mk_event(EV_RUNS, sl_pid[lvl_q[top][lvl_head[top]]], t, 0, 0));
      end
    end
    sched_clock = t + 1;
    if (evs.size() > 0) evs[evs.size() - 1].fin = 1;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && event_valid) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: res %0d pid %0h", event_res, event_pid);
        errors++;
      end else begin
        event_t e;
        e = pending_events[0];
        pending_events.delete(0);
        cmp_field("event_res", e.res, event_res);
        cmp_field("event_pid", e.pid, event_pid);
        cmp_field("event_time", e.tstamp, event_time);
        cmp_field("turnaround", e.ta, turnaround);
        cmp_field("queue_wait", e.wt, queue_wait);
        cmp_field("last", e.fin, last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || event_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // hold start across back-to-back transactions; drop it only for an idle burst
  task automatic issue(logic md, logic [15:0] pid, logic [15:0] burst, bit typed,
                       event_t ev);
    event_t evs[$];
    mode <= md;
    proc_id <= pid;
    burst_len <= burst;
    start <= 1;
    do @(posedge clk); while (busy);
    schedule_step(md, pid, burst, evs);
    if (typed) pending_events.insert(pending_events.size(), ev);
    else foreach (evs[i]) pending_events.insert(pending_events.size(), evs[i]);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending_events.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      CFG_LEVEL_COUNT: n_levels = data & 16'h7;
      CFG_TOP_QUANTUM: quantum0 = data & 16'h7FF;
      CFG_AGE_LIMIT:   promote_at = data;
      default: ;
    endcase
  endtask

  task automatic random_item(int arrival_pct);
    logic [15:0] burst;
    int pick;
    event_t none;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < arrival_pct) begin
      if (pick < 5) burst = 0;
      else if (pick < 8) burst = 16'($urandom);
      else if (pick < 10) burst = 16'hFFFF;
      else burst = 16'($urandom_range(1, 16));
      issue(0, 16'($urandom), burst, 0, none);
    end else begin
      issue(1, 16'($urandom), 16'($urandom), 0, none);
    end
  endtask

  row_t directed[$];
  int lc_set[] = '{2, 5, 0, 7, 1, 4, 6, 5, 3};
  int q_set[]  = '{1, 1024, 0, 3, 2, 1, 2047, 2, 1};
  int al_set[] = '{1, 65535, 0, 5, 2, 3, 1, 4, 1};

  initial begin
    row_t r;
    scheduler_reset();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    r = '{1, 16'h0000, 16'h0000, 0, mk_event(0, 0, 0, 0, 0)};
    directed.insert(directed.size(), r);
    r = '{0, 16'hFFFF, 16'h0000, 1, mk_event(EV_REJECTED, 16'hFFFF, 1, 0, 0)};
    r.ev.fin = 1;
    directed.insert(directed.size(), r);
    r = '{0, 16'h0000, 16'h0001, 0, mk_event(0, 0, 0, 0, 0)};
    directed.insert(directed.size(), r);
    r = '{1, 16'hFFFF, 16'hFFFF, 1, mk_event(EV_RUNS, 16'h0000, 1, 0, 0)};
    r.ev.fin = 1;
    directed.insert(directed.size(), r);
    r = '{1, 16'h0000, 16'h0000, 1, mk_event(EV_FINISHED, 16'h0000, 2, 1, 0)};
    r.ev.fin = 1;
    directed.insert(directed.size(), r);
    r = '{0, 16'hA5A5, 16'hFFFF, 0, mk_event(0, 0, 0, 0, 0)};
    directed.insert(directed.size(), r);
    r = '{0, 16'h5A5A, 16'h0003, 0, mk_event(0, 0, 0, 0, 0)};
    directed.insert(directed.size(), r);
    for (int i = 0; i < 10; i++) begin
      r = '{1, 16'h0000, 16'h0000, 0, mk_event(0, 0, 0, 0, 0)};
      directed.insert(directed.size(), r);
    end
    r = '{0, 16'h1234, 16'h0002, 0, mk_event(0, 0, 0, 0, 0)};
    directed.insert(directed.size(), r);
    for (int i = 0; i < 5; i++) begin
      r = '{1, 16'h0000, 16'h0000, 0, mk_event(0, 0, 0, 0, 0)};
      directed.insert(directed.size(), r);
    end
    foreach (directed[i])
      issue(directed[i].md, directed[i].pid, directed[i].burst, directed[i].typed,
            directed[i].ev);

    foreach (lc_set[p]) begin
      drain();
      write_reg(CFG_LEVEL_COUNT, 16'(lc_set[p]) | 16'($urandom_range(0, 8191) << 3));
      write_reg(CFG_TOP_QUANTUM, 16'(q_set[p]) | 16'($urandom_range(0, 31) << 11));
      write_reg(CFG_AGE_LIMIT, 16'(al_set[p]));
      if (p == lc_set.size() - 1) begin
        for (int i = 0; i < 90; i++) random_item(80);
        no_idle = 1;
      end
      for (int i = 0; i < 140; i++) random_item(45);
    end

    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mfs_pkg.sv
sv/mfs_ctrl.sv
sv/mfs_datapath.sv
sv/multilevel_feedback_scheduler.sv
test/tb.sv
